// ----- rtl/expression_lexer_assert.svh -----
// expression_lexer_assert.svh: assertion macros used by the lexer port checks.
// Depends on nothing; include by bare file name.
`ifndef EXPRESSION_LEXER_ASSERT_SVH
`define EXPRESSION_LEXER_ASSERT_SVH

// Antecedent implies consequent in the same cycle.
`define EXLEX_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("expression_lexer check failed");

// Antecedent implies consequent in the next cycle.
`define EXLEX_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("expression_lexer check failed");

`endif

// ----- rtl/exlex_pkg.sv -----
// exlex_pkg: token codes, character codes, keyword states and the token bundle
// passed from the lexer front to the back. No dependencies.
`default_nettype none

package exlex_pkg;

   localparam int VALUE_W = 32;

   // token kinds
   localparam logic [2:0] KIND_NUMBER   = 3'd0;
   localparam logic [2:0] KIND_OPERATOR = 3'd1;
   localparam logic [2:0] KIND_FUNCTION = 3'd2;
   localparam logic [2:0] KIND_VARIABLE = 3'd3;
   localparam logic [2:0] KIND_LPAREN   = 3'd4;
   localparam logic [2:0] KIND_RPAREN   = 3'd5;
   localparam logic [2:0] KIND_END      = 3'd6;

   // operator codes
   localparam logic [2:0] OP_MUL = 3'd0;
   localparam logic [2:0] OP_DIV = 3'd1;
   localparam logic [2:0] OP_ADD = 3'd2;
   localparam logic [2:0] OP_SUB = 3'd3;
   localparam logic [2:0] OP_POW = 3'd4;

   // function codes
   localparam logic [1:0] FN_SIN = 2'd0;
   localparam logic [1:0] FN_COS = 2'd1;
   localparam logic [1:0] FN_TAN = 2'd2;

   // ASCII codes
   localparam logic [7:0] CHAR_ZERO   = 8'h30;
   localparam logic [7:0] CHAR_NINE   = 8'h39;
   localparam logic [7:0] CHAR_S      = 8'h73;
   localparam logic [7:0] CHAR_I      = 8'h69;
   localparam logic [7:0] CHAR_N      = 8'h6E;
   localparam logic [7:0] CHAR_C      = 8'h63;
   localparam logic [7:0] CHAR_O      = 8'h6F;
   localparam logic [7:0] CHAR_T      = 8'h74;
   localparam logic [7:0] CHAR_A      = 8'h61;
   localparam logic [7:0] CHAR_X      = 8'h78;
   localparam logic [7:0] CHAR_STAR   = 8'h2A;
   localparam logic [7:0] CHAR_SLASH  = 8'h2F;
   localparam logic [7:0] CHAR_PLUS   = 8'h2B;
   localparam logic [7:0] CHAR_MINUS  = 8'h2D;
   localparam logic [7:0] CHAR_CARET  = 8'h5E;
   localparam logic [7:0] CHAR_LPAREN = 8'h28;
   localparam logic [7:0] CHAR_RPAREN = 8'h29;

   // partial keyword tracking
   typedef enum logic [2:0] {
      KW_IDLE = 3'd0,
      KW_S    = 3'd1,
      KW_SI   = 3'd2,
      KW_C    = 3'd3,
      KW_CO   = 3'd4,
      KW_T    = 3'd5,
      KW_TA   = 3'd6
   } kw_state_type;

   // Tokens caused by one request, always in this order:
   // number, inserted multiply, main token, end.
   typedef struct packed {
      logic               num_valid;
      logic [VALUE_W-1:0] num_value;
      logic               mul_valid;
      logic               main_valid;
      logic [2:0]         main_kind;
      logic [2:0]         main_op;
      logic [1:0]         main_fn;
      logic               end_valid;
   } token_bundle_type;

endpackage

`default_nettype wire

// ----- rtl/exlex_front.sv -----
// exlex_front: classifies each request character, keeps the digit accumulator
// and keyword progress, and builds the token bundle. Depends on exlex_pkg.
`default_nettype none

module exlex_front #(
   parameter int NUMBER_WIDTH = 32
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        accept,
   input  wire logic [7:0]                  character,
   input  wire logic                        end_of_text,
   output      logic                        push,
   output      exlex_pkg::token_bundle_type bundle
);

   logic [NUMBER_WIDTH-1:0]   acc_ff, acc_in;
   logic                      pend_ff, pend_in;
   exlex_pkg::kw_state_type   kw_ff, kw_in;

   logic                      is_digit;
   logic [NUMBER_WIDTH+3:0]   mac;
   logic                      sat;
   logic [NUMBER_WIDTH-1:0]   acc_digit;
   logic [63:0]               ext_digit, ext_old;
   logic                      consumed;

   // acc*10 + digit, saturating at all ones
   assign is_digit  = (character >= exlex_pkg::CHAR_ZERO) &&
                      (character <= exlex_pkg::CHAR_NINE);
   assign mac       = {1'b0, acc_ff, 3'b000} + {3'b000, acc_ff, 1'b0} +
                      {{NUMBER_WIDTH{1'b0}}, character[3:0]};
   assign sat       = |mac[NUMBER_WIDTH+3:NUMBER_WIDTH];
   assign acc_digit = sat ? {NUMBER_WIDTH{1'b1}} : mac[NUMBER_WIDTH-1:0];
   assign ext_digit = 64'(acc_digit);
   assign ext_old   = 64'(acc_ff);

   // classification, keyword state machine, bundle build
   always_comb begin
      acc_in   = acc_ff;
      pend_in  = pend_ff;
      kw_in    = kw_ff;
      consumed = 1'b0;
      bundle   = '0;

      if (is_digit) begin
         kw_in            = exlex_pkg::KW_IDLE;
         acc_in           = acc_digit;
         pend_in          = 1'b1;
         bundle.num_valid = end_of_text;
         bundle.num_value = ext_digit[exlex_pkg::VALUE_W-1:0];
      end else begin
         bundle.num_valid = pend_ff;
         bundle.num_value = ext_old[exlex_pkg::VALUE_W-1:0];
         acc_in           = '0;
         pend_in          = 1'b0;

         // continue a partial keyword
         unique case (kw_ff)
            exlex_pkg::KW_S: begin
               if (character == exlex_pkg::CHAR_I) begin
                  kw_in    = exlex_pkg::KW_SI;
                  consumed = 1'b1;
               end
            end
            exlex_pkg::KW_SI: begin
               if (character == exlex_pkg::CHAR_N) begin
                  kw_in             = exlex_pkg::KW_IDLE;
                  consumed          = 1'b1;
                  bundle.main_valid = 1'b1;
                  bundle.main_kind  = exlex_pkg::KIND_FUNCTION;
                  bundle.main_fn    = exlex_pkg::FN_SIN;
               end
            end
            exlex_pkg::KW_C: begin
               if (character == exlex_pkg::CHAR_O) begin
                  kw_in    = exlex_pkg::KW_CO;
                  consumed = 1'b1;
               end
            end
            exlex_pkg::KW_CO: begin
               if (character == exlex_pkg::CHAR_S) begin
                  kw_in             = exlex_pkg::KW_IDLE;
                  consumed          = 1'b1;
                  bundle.main_valid = 1'b1;
                  bundle.main_kind  = exlex_pkg::KIND_FUNCTION;
                  bundle.main_fn    = exlex_pkg::FN_COS;
               end
            end
            exlex_pkg::KW_T: begin
               if (character == exlex_pkg::CHAR_A) begin
                  kw_in    = exlex_pkg::KW_TA;
                  consumed = 1'b1;
               end
            end
            exlex_pkg::KW_TA: begin
               if (character == exlex_pkg::CHAR_N) begin
                  kw_in             = exlex_pkg::KW_IDLE;
                  consumed          = 1'b1;
                  bundle.main_valid = 1'b1;
                  bundle.main_kind  = exlex_pkg::KIND_FUNCTION;
                  bundle.main_fn    = exlex_pkg::FN_TAN;
               end
            end
            default: ;
         endcase

         // mismatch or idle: handle the character fresh
         if (!consumed) begin
            kw_in = exlex_pkg::KW_IDLE;
            unique case (character)
               exlex_pkg::CHAR_S: begin
                  bundle.mul_valid = pend_ff;
                  kw_in            = exlex_pkg::KW_S;
               end
               exlex_pkg::CHAR_C: begin
                  bundle.mul_valid = pend_ff;
                  kw_in            = exlex_pkg::KW_C;
               end
               exlex_pkg::CHAR_T: begin
                  bundle.mul_valid = pend_ff;
                  kw_in            = exlex_pkg::KW_T;
               end
               exlex_pkg::CHAR_X: begin
                  bundle.mul_valid  = pend_ff;
                  bundle.main_valid = 1'b1;
                  bundle.main_kind  = exlex_pkg::KIND_VARIABLE;
               end
               exlex_pkg::CHAR_STAR: begin
                  bundle.main_valid = 1'b1;
                  bundle.main_kind  = exlex_pkg::KIND_OPERATOR;
                  bundle.main_op    = exlex_pkg::OP_MUL;
               end
               exlex_pkg::CHAR_SLASH: begin
                  bundle.main_valid = 1'b1;
                  bundle.main_kind  = exlex_pkg::KIND_OPERATOR;
                  bundle.main_op    = exlex_pkg::OP_DIV;
               end
               exlex_pkg::CHAR_PLUS: begin
                  bundle.main_valid = 1'b1;
                  bundle.main_kind  = exlex_pkg::KIND_OPERATOR;
                  bundle.main_op    = exlex_pkg::OP_ADD;
               end
               exlex_pkg::CHAR_MINUS: begin
                  bundle.main_valid = 1'b1;
                  bundle.main_kind  = exlex_pkg::KIND_OPERATOR;
                  bundle.main_op    = exlex_pkg::OP_SUB;
               end
               exlex_pkg::CHAR_CARET: begin
                  bundle.main_valid = 1'b1;
                  bundle.main_kind  = exlex_pkg::KIND_OPERATOR;
                  bundle.main_op    = exlex_pkg::OP_POW;
               end
               exlex_pkg::CHAR_LPAREN: begin
                  bundle.main_valid = 1'b1;
                  bundle.main_kind  = exlex_pkg::KIND_LPAREN;
               end
               exlex_pkg::CHAR_RPAREN: begin
                  bundle.main_valid = 1'b1;
                  bundle.main_kind  = exlex_pkg::KIND_RPAREN;
               end
               default: ;
            endcase
         end
      end

      // end of text: close everything and return to reset state
      if (end_of_text) begin
         bundle.end_valid = 1'b1;
         acc_in           = '0;
         pend_in          = 1'b0;
         kw_in            = exlex_pkg::KW_IDLE;
      end
   end

   // only bundles carrying tokens enter the queue
   assign push = accept & (bundle.num_valid | bundle.mul_valid |
                           bundle.main_valid | bundle.end_valid);

   // lexer state
   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff  <= '0;
         pend_ff <= 1'b0;
         kw_ff   <= exlex_pkg::KW_IDLE;
      end else if (accept) begin
         acc_ff  <= acc_in;
         pend_ff <= pend_in;
         kw_ff   <= kw_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/exlex_queue.sv -----
// exlex_queue: two-entry queue of token bundles between front and back.
// Depends on exlex_pkg.
`default_nettype none

module exlex_queue (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        push,
   input  wire exlex_pkg::token_bundle_type push_data,
   input  wire logic                        pop,
   output      logic                        full,
   output      logic                        empty,
   output      exlex_pkg::token_bundle_type head
);

   exlex_pkg::token_bundle_type mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full  = (count_ff == 2'd2);
   assign empty = (count_ff == 2'd0);
   assign head  = mem_ff[rd_ptr_ff];

   // pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/exlex_back.sv -----
// exlex_back: walks the head bundle and delivers its tokens one per response.
// Depends on exlex_pkg.
`default_nettype none

module exlex_back (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        empty,
   input  wire exlex_pkg::token_bundle_type head,
   output      logic                        pop,
   output      logic                        rsp_valid,
   input  wire logic                        rsp_ready,
   output      logic [2:0]                  rsp_token_kind,
   output      logic [2:0]                  rsp_operator_code,
   output      logic [1:0]                  rsp_function_code,
   output      logic [31:0]                 rsp_number_value,
   output      logic                        rsp_last_in_run
);

   // bit order: number, multiply, main, end
   logic [3:0] sent_ff, sent_in;
   logic [3:0] flags;
   logic [3:0] remaining;
   logic [3:0] sel;
   logic       rsp_accept;

   assign flags     = {head.end_valid, head.main_valid, head.mul_valid, head.num_valid};
   assign remaining = flags & ~sent_ff;
   assign rsp_valid = ~empty;
   assign rsp_accept = rsp_valid & rsp_ready;
   assign rsp_last_in_run = ((remaining & ~sel) == 4'b0000);
   assign pop       = rsp_accept & rsp_last_in_run;

   // pick the earliest unsent token and drive its fields
   always_comb begin
      sel               = 4'b0000;
      rsp_token_kind    = exlex_pkg::KIND_END;
      rsp_operator_code = 3'd0;
      rsp_function_code = 2'd0;
      rsp_number_value  = '0;
      priority if (remaining[0]) begin
         sel              = 4'b0001;
         rsp_token_kind   = exlex_pkg::KIND_NUMBER;
         rsp_number_value = head.num_value;
      end else if (remaining[1]) begin
         sel               = 4'b0010;
         rsp_token_kind    = exlex_pkg::KIND_OPERATOR;
         rsp_operator_code = exlex_pkg::OP_MUL;
      end else if (remaining[2]) begin
         sel               = 4'b0100;
         rsp_token_kind    = head.main_kind;
         rsp_operator_code = head.main_op;
         rsp_function_code = head.main_fn;
      end else if (remaining[3]) begin
         sel = 4'b1000;
      end else begin
         sel = 4'b0000;
      end
   end

   // track tokens already delivered from the head bundle
   always_comb begin
      sent_in = sent_ff;
      if (pop) begin
         sent_in = 4'b0000;
      end else if (rsp_accept) begin
         sent_in = sent_ff | sel;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sent_ff <= 4'b0000;
      end else begin
         sent_ff <= sent_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/expression_lexer.sv -----
// expression_lexer: top level of the expression tokenizer; front, queue, back.
// Depends on exlex_pkg, exlex_front, exlex_queue, exlex_back.
//
//   channel | direction | fields
//   req_    | in        | character, end_of_text
//   rsp_    | out       | token_kind, operator_code, function_code, number_value,
//           |           | last_in_run
//
// A request is classified in the cycle it is accepted; its tokens are
// registered in the bundle queue and leave one per cycle while rsp_ready is
// high; a request gives 0 to 4 tokens at the output (one per response).
// The two-entry bundle queue sets req_ready: it drops only while the queue is
// full, i.e. while multi-token requests or rsp_ready low hold the back end.
// Reset is synchronous and clears lexer state and the queue.

`default_nettype none

module expression_lexer #(
   parameter int NUMBER_WIDTH = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output      logic        req_ready,
   input  wire logic [7:0]  req_character,
   input  wire logic        req_end_of_text,
   output      logic        rsp_valid,
   input  wire logic        rsp_ready,
   output      logic [2:0]  rsp_token_kind,
   output      logic [2:0]  rsp_operator_code,
   output      logic [1:0]  rsp_function_code,
   output      logic [31:0] rsp_number_value,
   output      logic        rsp_last_in_run
);

   logic                        accept;
   logic                        push;
   logic                        pop;
   logic                        full;
   logic                        empty;
   exlex_pkg::token_bundle_type front_bundle;
   exlex_pkg::token_bundle_type head;

   assign req_ready = ~full;
   assign accept    = req_valid & req_ready;

   // classification and lexer state
   exlex_front #(
      .NUMBER_WIDTH (NUMBER_WIDTH)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .character   (req_character),
      .end_of_text (req_end_of_text),
      .push        (push),
      .bundle      (front_bundle)
   );

   // decoupling queue
   exlex_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (front_bundle),
      .pop       (pop),
      .full      (full),
      .empty     (empty),
      .head      (head)
   );

   // token delivery
   exlex_back u_back (
      .clock             (clock),
      .reset             (reset),
      .empty             (empty),
      .head              (head),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_token_kind    (rsp_token_kind),
      .rsp_operator_code (rsp_operator_code),
      .rsp_function_code (rsp_function_code),
      .rsp_number_value  (rsp_number_value),
      .rsp_last_in_run   (rsp_last_in_run)
   );

endmodule

`default_nettype wire

// ----- rtl/expression_lexer_checker.sv -----
// expression_lexer_props: port-level checks on the lexer, bound to the top.
// Depends on exlex_pkg and expression_lexer_assert.svh.
`default_nettype none

`include "expression_lexer_assert.svh"

module expression_lexer_props (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic [7:0]  req_character,
   input wire logic        req_end_of_text,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [2:0]  rsp_token_kind,
   input wire logic [2:0]  rsp_operator_code,
   input wire logic [1:0]  rsp_function_code,
   input wire logic [31:0] rsp_number_value,
   input wire logic        rsp_last_in_run
);

   logic        req_seen;
   logic        rsp_end;
   logic [40:0] rsp_fields;

   assign req_seen = req_valid & req_ready & (req_character != 8'h00 | req_end_of_text);
   assign rsp_end  = rsp_valid & (rsp_token_kind == exlex_pkg::KIND_END);

   // every response field in one vector
   assign rsp_fields = {rsp_token_kind, rsp_operator_code, rsp_function_code,
                        rsp_number_value, rsp_last_in_run};

   // a stalled response holds
   `EXLEX_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_fields))

   // the end token closes the run of its request
   `EXLEX_ASSERT_SAME(a_end_last, clock, reset, rsp_end, rsp_last_in_run)

   // only number tokens carry a value, only operators an operator code
   `EXLEX_ASSERT_SAME(a_value_zero, clock, reset, rsp_valid && rsp_token_kind != exlex_pkg::KIND_NUMBER, rsp_number_value == 32'd0)
   `EXLEX_ASSERT_SAME(a_op_zero, clock, reset, rsp_valid && rsp_token_kind != exlex_pkg::KIND_OPERATOR, rsp_operator_code == exlex_pkg::OP_MUL)

   // no response appears in the cycle after reset
   `EXLEX_ASSERT_SAME(a_reset_quiet, clock, reset, $past(reset) && !req_seen, !rsp_valid)

endmodule

bind expression_lexer expression_lexer_props u_expression_lexer_props (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_ready         (req_ready),
   .req_character     (req_character),
   .req_end_of_text   (req_end_of_text),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_token_kind    (rsp_token_kind),
   .rsp_operator_code (rsp_operator_code),
   .rsp_function_code (rsp_function_code),
   .rsp_number_value  (rsp_number_value),
   .rsp_last_in_run   (rsp_last_in_run)
);

`default_nettype wire

// ----- tb/sv/expression_lexer_checker.sv -----
`timescale 1ns / 1ps
// expression_lexer_checker: watches both channels of the expression lexer, predicts the
// tokens of every accepted request and compares them with the tokens that come out.
// Depends on exlex_pkg for token, operator, function and character codes.

module expression_lexer_checker
   import exlex_pkg::*;
#(
   parameter int NUMBER_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [7:0]  req_character,
   input  logic        req_end_of_text,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [2:0]  rsp_token_kind,
   input  logic [2:0]  rsp_operator_code,
   input  logic [1:0]  rsp_function_code,
   input  logic [31:0] rsp_number_value,
   input  logic        rsp_last_in_run,
   output int          error_count,
   output int          pending_tokens,
   output int          tokens_checked
);

   localparam logic [63:0] NUMBER_LIMIT = ~64'd0 >> (64 - NUMBER_WIDTH);

   typedef struct packed {
      logic [2:0]  kind;
      logic [2:0]  op;
      logic [1:0]  fn;
      logic [31:0] value;
      logic        last;
   } lex_token_t;

   lex_token_t   expected_tokens[$];
   lex_token_t   step_tokens[$];

   // lexer state as the block should hold it
   logic [63:0]  number_acc;
   logic         digits_open;
   kw_state_type kw_state;

   task automatic add_token(input logic [2:0] kind, input logic [2:0] op,
                            input logic [1:0] fn, input logic [63:0] value);
      lex_token_t tok;
      tok.kind  = kind;
      tok.op    = op;
      tok.fn    = fn;
      tok.value = value[31:0];
      tok.last  = 1'b0;
      step_tokens.push_back(tok);
   endtask

   // Tokens for one request, appended to the expected queue in order.
   task automatic tokenize_char(input logic [7:0] ch, input logic eot);
      logic        after_digit;
      logic        consumed;
      logic [63:0] digit;
      lex_token_t  tok;
      step_tokens.delete();
      if (ch >= CHAR_ZERO && ch <= CHAR_NINE) begin
         // digit: extend the run, saturating at the limit
         digit = 64'(ch - CHAR_ZERO);
         kw_state = KW_IDLE;
         if (number_acc > (NUMBER_LIMIT - digit) / 10)
            number_acc = NUMBER_LIMIT;
         else
            number_acc = number_acc * 10 + digit;
         digits_open = 1'b1;
      end else begin
         after_digit = digits_open;
         consumed = 1'b0;
         // any non-digit closes an open number
         if (digits_open) begin
            add_token(KIND_NUMBER, '0, '0, number_acc);
            digits_open = 1'b0;
            number_acc = '0;
         end
         // try to continue a partial keyword
         case (kw_state)
            KW_S:  if (ch == CHAR_I) begin kw_state = KW_SI; consumed = 1'b1; end
            KW_SI: if (ch == CHAR_N) begin
               add_token(KIND_FUNCTION, '0, FN_SIN, '0);
               kw_state = KW_IDLE;
               consumed = 1'b1;
            end
            KW_C:  if (ch == CHAR_O) begin kw_state = KW_CO; consumed = 1'b1; end
            KW_CO: if (ch == CHAR_S) begin
               add_token(KIND_FUNCTION, '0, FN_COS, '0);
               kw_state = KW_IDLE;
               consumed = 1'b1;
            end
            KW_T:  if (ch == CHAR_A) begin kw_state = KW_TA; consumed = 1'b1; end
            KW_TA: if (ch == CHAR_N) begin
               add_token(KIND_FUNCTION, '0, FN_TAN, '0);
               kw_state = KW_IDLE;
               consumed = 1'b1;
            end
            default: ;
         endcase
         // mismatch drops the partial keyword; character is handled afresh
         if (!consumed) begin
            kw_state = KW_IDLE;
            case (ch)
               CHAR_S, CHAR_C, CHAR_T: begin
                  if (after_digit) add_token(KIND_OPERATOR, OP_MUL, '0, '0);
                  kw_state = (ch == CHAR_S) ? KW_S : (ch == CHAR_C) ? KW_C : KW_T;
               end
               CHAR_X: begin
                  if (after_digit) add_token(KIND_OPERATOR, OP_MUL, '0, '0);
                  add_token(KIND_VARIABLE, '0, '0, '0);
               end
               CHAR_STAR:   add_token(KIND_OPERATOR, OP_MUL, '0, '0);
               CHAR_SLASH:  add_token(KIND_OPERATOR, OP_DIV, '0, '0);
               CHAR_PLUS:   add_token(KIND_OPERATOR, OP_ADD, '0, '0);
               CHAR_MINUS:  add_token(KIND_OPERATOR, OP_SUB, '0, '0);
               CHAR_CARET:  add_token(KIND_OPERATOR, OP_POW, '0, '0);
               CHAR_LPAREN: add_token(KIND_LPAREN, '0, '0, '0);
               CHAR_RPAREN: add_token(KIND_RPAREN, '0, '0, '0);
               default: ;
            endcase
         end
      end
      // end of text: flush the number, then the end token, then clear state
      if (eot) begin
         if (digits_open) add_token(KIND_NUMBER, '0, '0, number_acc);
         add_token(KIND_END, '0, '0, '0);
         number_acc = '0;
         digits_open = 1'b0;
         kw_state = KW_IDLE;
      end
      for (int i = 0; i < step_tokens.size(); i++) begin
         tok = step_tokens[i];
         tok.last = (i == step_tokens.size() - 1);
         expected_tokens.push_back(tok);
      end
   endtask

   task automatic compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endtask

   task automatic check_token();
      lex_token_t want;
      if (expected_tokens.size() == 0) begin
         $error("token with no request behind it: kind %0d value %0d",
                rsp_token_kind, rsp_number_value);
         error_count++;
      end else begin
         want = expected_tokens.pop_front();
         compare_field("token_kind", want.kind, rsp_token_kind);
         compare_field("operator_code", want.op, rsp_operator_code);
         compare_field("function_code", want.fn, rsp_function_code);
         compare_field("number_value", want.value, rsp_number_value);
         compare_field("last_in_run", want.last, rsp_last_in_run);
         tokens_checked++;
      end
   endtask

   // tokens out are checked before the new request is predicted
   always @(posedge clock) begin
      if (reset) begin
         expected_tokens.delete();
         number_acc = '0;
         digits_open = 1'b0;
         kw_state = KW_IDLE;
         error_count = 0;
         tokens_checked = 0;
      end else begin
         if (rsp_valid && rsp_ready) check_token();
         if (req_valid && req_ready) tokenize_char(req_character, req_end_of_text);
      end
      pending_tokens = expected_tokens.size();
   end

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
// testbench: drives character requests into expression_lexer with random gaps on both
// sides and reports the verdict. Depends on exlex_pkg, expression_lexer and the checker.

module testbench;
   import exlex_pkg::*;

   localparam int IDLE_LIMIT   = 2000;
   localparam int RANDOM_ITEMS = 200;
   localparam int DRAIN_CYCLES = 20;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_character = '0;
   logic        req_end_of_text = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [2:0]  rsp_token_kind;
   logic [2:0]  rsp_operator_code;
   logic [1:0]  rsp_function_code;
   logic [31:0] rsp_number_value;
   logic        rsp_last_in_run;

   int error_count;
   int pending_tokens;
   int tokens_checked;
   int requests_sent = 0;
   int expressions_sent = 0;
   int idle_cycles = 0;
   int req_calm = 0;
   int rsp_calm = 0;
   logic [7:0] text_buf[$];

   expression_lexer dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_character     (req_character),
      .req_end_of_text   (req_end_of_text),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_token_kind    (rsp_token_kind),
      .rsp_operator_code (rsp_operator_code),
      .rsp_function_code (rsp_function_code),
      .rsp_number_value  (rsp_number_value),
      .rsp_last_in_run   (rsp_last_in_run)
   );

   expression_lexer_checker lexer_check (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_character     (req_character),
      .req_end_of_text   (req_end_of_text),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_token_kind    (rsp_token_kind),
      .rsp_operator_code (rsp_operator_code),
      .rsp_function_code (rsp_function_code),
      .rsp_number_value  (rsp_number_value),
      .rsp_last_in_run   (rsp_last_in_run),
      .error_count       (error_count),
      .pending_tokens    (pending_tokens),
      .tokens_checked    (tokens_checked)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // gap before the next item; now and then a calm stretch with no gaps
   function automatic int draw_gap(inout int calm_left);
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      if ($urandom_range(0, 15) == 0) begin
         calm_left = $urandom_range(8, 30);
         return 0;
      end
      return $urandom_range(0, 17);
   endfunction

   task automatic send_request(input logic [7:0] ch, input logic eot);
      int gap;
      gap = draw_gap(req_calm);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_character   <= ch;
      req_end_of_text <= eot;
      do @(posedge clock); while (!(req_valid && req_ready));
      @(negedge clock);
      requests_sent++;
   endtask

   task automatic add_text(input string s);
      for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
   endtask

   // send the buffered characters; eot marks the last one
   task automatic flush_text(input logic eot);
      int count;
      count = text_buf.size();
      for (int i = 0; i < count; i++) send_request(text_buf[i], eot && (i == count - 1));
      text_buf.delete();
      if (eot) expressions_sent++;
   endtask

   // one piece of a mostly well-formed expression, with some noise
   task automatic add_random_piece();
      int len;
      case ($urandom_range(0, 9))
         0, 1: begin
            len = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 12) : $urandom_range(1, 3);
            repeat (len) text_buf.push_back(8'($urandom_range(CHAR_ZERO, CHAR_NINE)));
         end
         2: case ($urandom_range(0, 4))
            0: add_text("*");
            1: add_text("/");
            2: add_text("+");
            3: add_text("-");
            default: add_text("^");
         endcase
         3: add_text(($urandom_range(0, 1) == 0) ? "(" : ")");
         4: add_text("x");
         5, 6: case ($urandom_range(0, 2))
            0: add_text("sin");
            1: add_text("cos");
            default: add_text("tan");
         endcase
         // broken keyword; whatever follows decides what happens
         7: case ($urandom_range(0, 5))
            0: add_text("s");
            1: add_text("si");
            2: add_text("c");
            3: add_text("co");
            4: add_text("t");
            default: add_text("ta");
         endcase
         default: text_buf.push_back(8'($urandom_range(0, 255)));
      endcase
   endtask

   // result side: random stall before each token
   initial begin
      int gap;
      wait (!reset);
      @(negedge clock);
      forever begin
         gap = draw_gap(rsp_calm);
         if (gap != 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
         @(negedge clock);
      end
   end

   // watchdog: cycles with no request or token accepted
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
            $display("expression_lexer: mismatch");
            $finish;
         end
      end
   end

   // stimulus and verdict
   initial begin
      int random_goal;
      int pieces;
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      // first character right after reset, no multiply before it
      add_text("x");
      flush_text(1'b0);
      add_text("(");
      flush_text(1'b0);
      // multiply inserted before a keyword after a digit
      add_text("3sin");
      flush_text(1'b0);
      // partial tan dropped, the mismatching c starts cos
      add_text("tcos");
      flush_text(1'b0);
      add_text("*/+-^");
      flush_text(1'b0);
      // keyword completed on the last character of the text
      add_text("tan");
      flush_text(1'b1);
      // saturated number closed by a paren at the end of the text
      add_text("9999999999)");
      flush_text(1'b1);
      // number pending at end of text, flushed before the end token
      add_text("9x42");
      flush_text(1'b1);

      random_goal = requests_sent + RANDOM_ITEMS;
      while (requests_sent < random_goal) begin
         pieces = $urandom_range(1, 10);
         repeat (pieces) add_random_piece();
         flush_text(1'b1);
      end
      req_valid <= 1'b0;

      wait (pending_tokens == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (pending_tokens != 0) $error("%0d expected tokens never arrived", pending_tokens);
      $display("run covered %0d requests in %0d expressions, %0d tokens compared",
               requests_sent, expressions_sent, tokens_checked);
      $display("with keywords, broken keywords, saturated numbers and noise bytes");
      if (error_count == 0 && pending_tokens == 0) begin
         $display("expression_lexer: match");
      end else begin
         $display("expression_lexer: mismatch");
      end
      $finish;
   end

endmodule
